FILE: rtl/pattern_started_line_framer_core_defines.svh
// ----------------------------------------------------------------------------
// Line framer assertion macros
// Shared property wrappers for the framer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PATTERN_STARTED_LINE_FRAMER_CORE_DEFINES_SVH
`define PATTERN_STARTED_LINE_FRAMER_CORE_DEFINES_SVH

// Check prop on every clock edge outside reset.
`define PSLF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check an implication in the next cycle outside reset.
`define PSLF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pslf_pkg.sv
// ----------------------------------------------------------------------------
// Line framer package
// Register map, state codes and fixed byte values of the line framer.
// ----------------------------------------------------------------------------
package pslf_pkg;

    localparam int unsigned APB_AW = 5;
    localparam int unsigned APB_DW = 64;

    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_PATTERN = 2'd0;
    localparam t_reg_idx REG_PLEN    = 2'd1;
    localparam t_reg_idx REG_LIMIT   = 2'd2;

    typedef logic [1:0] t_state;

    localparam t_state ST_HUNT  = 2'd0;
    localparam t_state ST_LINE  = 2'd1;
    localparam t_state ST_DRAIN = 2'd2;

    localparam logic [7:0]  NEWLINE_BYTE  = 8'h0A;
    localparam logic [63:0] PATTERN_RESET = 64'h24;
    localparam logic [3:0]  PLEN_RESET    = 4'd1;
    localparam logic [6:0]  LIMIT_RESET   = 7'd64;

endpackage

FILE: rtl/pattern_started_line_framer_core.sv
// ----------------------------------------------------------------------------
// Pattern-started line framer
// A received byte that completes the start pattern opens a line; the line is
// stored up to and including a newline and then streamed out with tlast on
// the newline. While hunting or storing, one byte is taken every clock cycle.
// A line is read back from the line store's single read port at one byte per
// cycle unless the output stalls, and intake stops until it is all read out;
// the last byte waits in the output register while intake already resumes.
// Lines that outgrow line_limit minus one bytes are dropped without output.
// ----------------------------------------------------------------------------
module pattern_started_line_framer_core #(
    parameter int MAX_LINE    = 64,
    parameter int MAX_PATTERN = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // stream in
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
    // stream out
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,   // [7:0] line_byte
    output logic                         m_axis_tlast,   // line_end
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pslf_pkg::APB_AW-1:0]  paddr,
    input  logic [pslf_pkg::APB_DW-1:0]  pwdata,
    output logic [pslf_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    import pslf_pkg::*;

`include "pattern_started_line_framer_core_defines.svh"

    localparam int FILL_MAX = (MAX_LINE - 1 > MAX_PATTERN) ? MAX_LINE - 1 : MAX_PATTERN;
    localparam int DEPTH    = FILL_MAX;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW       = $clog2(FILL_MAX + 1);
    localparam int MW       = $clog2(MAX_PATTERN + 1);

    // configuration registers
    logic [63:0]   r_pattern;
    logic [3:0]    r_plen;
    logic [6:0]    r_limit;

    // control state
    t_state        r_state,   n_state;
    logic [MW-1:0] r_match,   n_match;
    logic [FW-1:0] r_fill,    n_fill;
    logic [FW-1:0] r_len,     n_len;
    logic [FW-1:0] r_rd_idx,  n_rd_idx;
    logic          r_out_valid;
    logic          r_out_last;
    logic [7:0]    r_rd_data;

    logic [7:0]    mem [DEPTH];

    logic          w_cfg_wr;
    t_reg_idx      w_cfg_idx;
    logic          w_in_take;
    logic          w_out_take;
    logic [2:0]    w_pos;
    logic [7:0]    w_want;
    logic [MW-1:0] w_match_next;
    logic [MW-1:0] w_plen_eff;
    logic [6:0]    w_limit_eff;
    logic [FW-1:0] w_cap;
    logic          w_room;
    logic          w_line_done;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic          w_rd_issue;
    logic          w_rd_last;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[4:3];
    assign w_cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= PATTERN_RESET;
            r_plen    <= PLEN_RESET;
            r_limit   <= LIMIT_RESET;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_PATTERN: r_pattern <= pwdata;
                REG_PLEN:    r_plen    <= pwdata[3:0];
                REG_LIMIT:   r_limit   <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_PATTERN: prdata = r_pattern;
            REG_PLEN:    prdata = {60'd0, r_plen};
            REG_LIMIT:   prdata = {57'd0, r_limit};
            default:     prdata = '0;
        endcase
    end

    // ---------------- effective limits ----------------
    always_comb begin
        if (r_plen == 4'd0) begin
            w_plen_eff = MW'(1);
        end else if (r_plen > 4'(MAX_PATTERN)) begin
            w_plen_eff = MW'(MAX_PATTERN);
        end else begin
            w_plen_eff = MW'(r_plen);
        end
        if (r_limit < 7'd2) begin
            w_limit_eff = 7'd2;
        end else if (r_limit > 7'(MAX_LINE)) begin
            w_limit_eff = 7'(MAX_LINE);
        end else begin
            w_limit_eff = r_limit;
        end
    end

    assign w_cap = FW'(w_limit_eff - 7'd1);

    // ---------------- intake ----------------
    assign s_axis_tready = (r_state != ST_DRAIN);
    assign w_in_take     = s_axis_tvalid & s_axis_tready;

    assign w_pos        = 3'(r_match);
    assign w_want       = r_pattern[{w_pos, 3'b000} +: 8];
    assign w_match_next = MW'({1'b0, w_pos} + 4'd1);
    assign w_room       = (r_fill < w_cap);
    assign w_line_done  = w_in_take && (r_state == ST_LINE) && w_room
                          && (s_axis_tdata == NEWLINE_BYTE);

    // ---------------- readback ----------------
    assign w_out_take = r_out_valid & m_axis_tready;
    assign w_rd_issue = (r_state == ST_DRAIN) && (!r_out_valid || w_out_take);
    assign w_rd_last  = (r_rd_idx == FW'(r_len - 1'b1));

    always_comb begin
        n_state  = r_state;
        n_match  = r_match;
        n_fill   = r_fill;
        n_len    = r_len;
        n_rd_idx = r_rd_idx;
        w_we     = 1'b0;
        w_waddr  = r_fill[AW-1:0];
        case (r_state)
            ST_HUNT: begin
                w_waddr = AW'(w_pos);
                if (w_in_take) begin
                    if (s_axis_tdata == w_want) begin
                        w_we    = 1'b1;
                        n_match = w_match_next;
                        if (w_match_next >= w_plen_eff) begin
                            n_state = ST_LINE;
                            n_fill  = FW'(w_match_next);
                        end
                    end else begin
                        // drop the position; this byte is not retried
                        n_match = '0;
                    end
                end
            end
            ST_LINE: begin
                if (w_in_take) begin
                    if (w_room) begin
                        w_we   = 1'b1;
                        n_fill = FW'(r_fill + 1'b1);
                        if (s_axis_tdata == NEWLINE_BYTE) begin
                            n_len    = FW'(r_fill + 1'b1);
                            n_rd_idx = '0;
                            n_state  = ST_DRAIN;
                            n_match  = '0;
                            n_fill   = '0;
                        end
                    end else begin
                        // overflow: discard the line silently
                        n_state = ST_HUNT;
                        n_match = '0;
                        n_fill  = '0;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_rd_issue) begin
                    n_rd_idx = FW'(r_rd_idx + 1'b1);
                    if (w_rd_last) begin
                        n_state = ST_HUNT;
                    end
                end
            end
            default: begin
                n_state = ST_HUNT;
                n_match = '0;
                n_fill  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HUNT;
            r_match     <= '0;
            r_fill      <= '0;
            r_len       <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_match  <= n_match;
            r_fill   <= n_fill;
            r_len    <= n_len;
            r_rd_idx <= n_rd_idx;
            if (w_rd_issue) begin
                r_out_valid <= 1'b1;
                r_out_last  <= w_rd_last;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- line store ----------------
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= s_axis_tdata;
        end
    end

    // read data register doubles as the output register
    always_ff @(posedge i_clk) begin
        if (w_rd_issue) begin
            r_rd_data <= mem[r_rd_idx[AW-1:0]];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_rd_data;
    assign m_axis_tlast  = r_out_last;

    // ---------------- checks ----------------
    `PSLF_ASSERT(a_rd_in_line, (r_state == ST_DRAIN) |-> (r_rd_idx < r_len), "readback past line end")
    `PSLF_ASSERT(a_last_out_of_drain, (r_out_valid && r_out_last && (r_state == ST_DRAIN)) |-> (r_rd_idx == '0), "last byte still shown after next readback began")
    `PSLF_ASSERT(a_hunt_pos, (r_state == ST_HUNT) |-> (r_match < MW'(MAX_PATTERN)), "hunt position beyond pattern")
    `PSLF_ASSERT_NEXT(a_newline_drains, w_line_done, (r_state == ST_DRAIN) && (r_rd_idx == '0), "newline did not start readback")

endmodule
